### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hw/rtl/hvl_pkg.sv
package hvl_pkg;

	localparam int BYTE_W  = 8;
	localparam int LABEL_W = 7;
	localparam int NAME_W  = 9;

	localparam logic [LABEL_W-1:0] LABEL_MAX = 7'd63;
	localparam logic [LABEL_W-1:0] LABEL_SAT = 7'd127;
	localparam logic [NAME_W-1:0]  NAME_SAT  = 9'd511;

	localparam logic [BYTE_W-1:0] CHAR_DOT    = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_HYPHEN = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_UC_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UC_Z   = 8'h5A;
	localparam logic [BYTE_W-1:0] CHAR_LC_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LC_Z   = 8'h7A;
	localparam logic [BYTE_W-1:0] CHAR_0      = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9      = 8'h39;
	localparam logic [BYTE_W-1:0] CASE_GAP    = CHAR_LC_A - CHAR_UC_A;

	typedef struct packed {
		logic [BYTE_W-1:0] name_byte;
		logic              is_final;
	} item_t;

	function automatic logic is_upper(input logic [BYTE_W-1:0] c);
		return (c >= CHAR_UC_A) && (c <= CHAR_UC_Z);
	endfunction

	function automatic logic is_ldh(input logic [BYTE_W-1:0] c);
		return ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) || is_upper(c)
			|| ((c >= CHAR_0) && (c <= CHAR_9)) || (c == CHAR_HYPHEN);
	endfunction

	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
		return is_upper(c) ? c + CASE_GAP : c;
	endfunction

endpackage

### hw/rtl/hvl_if.sv
interface hvl_in_if;
	logic                       valid;
	logic                       ready;
	logic [hvl_pkg::BYTE_W-1:0] name_byte;
	logic                       is_final;

	modport source (output valid, output name_byte, output is_final, input ready);
	modport sink (input valid, input name_byte, input is_final, output ready);
endinterface

interface hvl_out_if;
	logic                       valid;
	logic                       ready;
	logic [hvl_pkg::BYTE_W-1:0] folded_byte;
	logic                       name_done;
	logic                       name_valid;

	modport source (output valid, output folded_byte, output name_done, output name_valid,
		input ready);
	modport sink (input valid, input folded_byte, input name_done, input name_valid,
		output ready);
endinterface

### hw/rtl/hostname_validate_lowercase_core.sv
// channel    | dir | payload                               | handshake
// name_ch    | in  | name_byte[7:0], is_final              | valid/ready
// result_ch  | out | folded_byte[7:0], name_done, name_valid | valid/ready
//
// One byte per cycle sustained while result_ch is not stalled.
// Path: input register (_s1), fold/check logic, result register (_q).
// Per-name counters update as the byte leaves _s1; is_final resets them.
// A stalled result holds _s1; the input takes a byte whenever _s1 drains.
// arst_n clears valids and the name state.
`include "assert_macros.svh"

module hostname_validate_lowercase_core #(
	parameter int MAX_NAME_LEN = 253
) (
	input logic          clk,
	input logic          arst_n,
	hvl_in_if.sink       name_ch,
	hvl_out_if.source    result_ch
);

	logic           valid_s1;
	hvl_pkg::item_t item_s1;
	logic           advance;
	logic           name_valid_c;

	logic                       out_valid_q;
	logic [hvl_pkg::BYTE_W-1:0] folded_q;
	logic                       done_q;
	logic                       nvalid_q;

	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign name_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (name_ch.ready)
			valid_s1 <= name_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (name_ch.ready && name_ch.valid) begin
			item_s1.name_byte <= name_ch.name_byte;
			item_s1.is_final  <= name_ch.is_final;
		end
	end

	hvl_tracker #(
		.MAX_NAME_LEN (MAX_NAME_LEN)
	) u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item       (item_s1),
		.name_valid (name_valid_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || result_ch.ready)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			folded_q <= hvl_pkg::fold(item_s1.name_byte);
			done_q   <= item_s1.is_final;
			nvalid_q <= name_valid_c;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.folded_byte = folded_q;
	assign result_ch.name_done   = done_q;
	assign result_ch.name_valid  = nvalid_q;

	`ASSERT_IMPL(a_stall_holds_s1, clk, arst_n, out_valid_q && !result_ch.ready, !advance)
	`ASSERT_IMPL(a_valid_needs_done, clk, arst_n, out_valid_q && nvalid_q, done_q)

endmodule

### hw/rtl/hvl_tracker.sv
`include "assert_macros.svh"

module hvl_tracker #(
	parameter int MAX_NAME_LEN = 253
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  hvl_pkg::item_t item,
	output logic           name_valid
);

	localparam logic [hvl_pkg::NAME_W-1:0] NAME_W_MAX = hvl_pkg::NAME_W'(MAX_NAME_LEN);

	logic [hvl_pkg::LABEL_W-1:0] label_count_q, label_count_d;
	logic [hvl_pkg::NAME_W-1:0]  name_count_q, name_count_d;
	logic                        prev_hyphen_q, prev_hyphen_d;
	logic                        failed_q;
	logic                        fail_d;
	logic                        is_dot, is_hyphen;
	logic                        label_bad_cur, label_bad_new;

	assign is_dot    = (item.name_byte == hvl_pkg::CHAR_DOT);
	assign is_hyphen = (item.name_byte == hvl_pkg::CHAR_HYPHEN);

	assign label_bad_cur = (label_count_q == '0) || (label_count_q > hvl_pkg::LABEL_MAX)
		|| prev_hyphen_q;

	always_comb begin
		fail_d       = failed_q;
		name_count_d = (name_count_q < hvl_pkg::NAME_SAT) ? name_count_q + 1'b1 : name_count_q;
		if (name_count_d > NAME_W_MAX)
			fail_d = 1'b1;
		if (is_dot) begin
			if (label_bad_cur)
				fail_d = 1'b1;
			label_count_d = '0;
			prev_hyphen_d = 1'b0;
		end else begin
			if (!hvl_pkg::is_ldh(item.name_byte))
				fail_d = 1'b1;
			if ((label_count_q == '0) && is_hyphen)
				fail_d = 1'b1;
			label_count_d = (label_count_q < hvl_pkg::LABEL_SAT) ?
				label_count_q + 1'b1 : label_count_q;
			prev_hyphen_d = is_hyphen;
		end
		label_bad_new = (label_count_d == '0) || (label_count_d > hvl_pkg::LABEL_MAX)
			|| prev_hyphen_d;
		if (item.is_final && label_bad_new)
			fail_d = 1'b1;
	end

	assign name_valid = item.is_final && !fail_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= '0;
			name_count_q  <= '0;
			prev_hyphen_q <= 1'b0;
			failed_q      <= 1'b0;
		end else if (advance) begin
			if (item.is_final) begin
				label_count_q <= '0;
				name_count_q  <= '0;
				prev_hyphen_q <= 1'b0;
				failed_q      <= 1'b0;
			end else begin
				label_count_q <= label_count_d;
				name_count_q  <= name_count_d;
				prev_hyphen_q <= prev_hyphen_d;
				failed_q      <= fail_d;
			end
		end
	end

	`ASSERT_NEXT(a_final_clears, clk, arst_n, advance && item.is_final,
		(name_count_q == '0) && (label_count_q == '0) && !failed_q)
	`ASSERT_IMPL(a_label_le_name, clk, arst_n, 1'b1, {2'b00, label_count_q} <= name_count_q)

endmodule
